// File: sv/brsm_pkg.sv
// Shared constants, types and a helper function for the byte ring space manager.
package brsm_pkg;

    localparam int CAPACITY = 4096;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = POS_W + 1;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] OP_CLAIM   = 2'd0;
    localparam logic [1:0] OP_PUBLISH = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] head;
        logic [CNT_W-1:0] tail;
        logic             pad_valid;
        logic [CNT_W-1:0] pad_start;
    } brsm_state_t;

    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] offset;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] used_bytes;
        logic [CNT_W-1:0] free_bytes;
        logic             data_wake;
        logic             space_wake;
    } brsm_result_t;

    // Occupancy from the free-running counters, saturated at the capacity.
    function automatic logic [CNT_W-1:0] used_of(input logic [CNT_W-1:0] head,
                                                 input logic [CNT_W-1:0] tail);
        logic [CNT_W-1:0] diff;
        diff = head - tail;
        return (diff > CAP_CNT) ? CAP_CNT : diff;
    endfunction

endpackage

// File: sv/brsm_core.sv
// Combinational operation logic: next ring state and result for one transaction.
module brsm_core
    import brsm_pkg::*;
(
    input  logic [1:0]       op,
    input  logic [CNT_W-1:0] amount,
    input  brsm_state_t      st,
    output brsm_state_t      st_next,
    output brsm_result_t     res
);

    always_comb
    begin
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] freeb;
        logic [CNT_W-1:0] head_till;
        logic [CNT_W:0]   wrap_need;
        logic [CNT_W-1:0] skip_till;
        logic [CNT_W-1:0] used_pk;
        logic [CNT_W-1:0] tail_pk;
        logic [CNT_W-1:0] run_till;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] pad_gap;
        logic [CNT_W-1:0] used_after;

        st_next   = st;
        res       = '0;
        used      = used_of(st.head, st.tail);
        freeb     = CAP_CNT - used;
        head_till = CAP_CNT - {1'b0, st.head[POS_W-1:0]};
        wrap_need = {1'b0, head_till} + {1'b0, amount};
        skip_till = '0;
        used_pk   = used;
        tail_pk   = st.tail;
        run_till  = '0;
        n         = '0;
        pad_gap   = st.pad_start - st.tail;

        case (op)
            OP_CLAIM:
            begin
                if (freeb != '0 && amount <= freeb)
                begin
                    if (amount <= head_till)
                    begin
                        res.granted = 1'b1;
                        res.offset  = st.head[POS_W-1:0];
                        res.length  = amount;
                    end
                    else if ({1'b0, freeb} >= wrap_need &&
                             {1'b0, st.tail[POS_W-1:0]} >= amount)
                    begin
                        // The bytes up to the ring end become a pad.
                        st_next.pad_valid = 1'b1;
                        st_next.pad_start = st.head;
                        st_next.head      = st.head + head_till;
                        res.granted       = 1'b1;
                        res.length        = amount;
                    end
                end
            end
            OP_PUBLISH:
            begin
                n             = (amount < freeb) ? amount : freeb;
                st_next.head  = st.head + n;
                res.length    = n;
                res.data_wake = 1'b1;
            end
            OP_PEEK:
            begin
                if (used != '0 && st.pad_valid && st.tail == st.pad_start)
                begin
                    skip_till = CAP_CNT - {1'b0, st.tail[POS_W-1:0]};
                    if (skip_till > used)
                    begin
                        skip_till = used;
                    end
                    res.space_wake    = (used == CAP_CNT);
                    tail_pk           = st.tail + skip_till;
                    st_next.pad_valid = 1'b0;
                    used_pk           = used - skip_till;
                end
                st_next.tail = tail_pk;
                if (used_pk != '0)
                begin
                    run_till    = CAP_CNT - {1'b0, tail_pk[POS_W-1:0]};
                    res.granted = 1'b1;
                    res.offset  = tail_pk[POS_W-1:0];
                    res.length  = (used_pk < run_till) ? used_pk : run_till;
                end
            end
            OP_RELEASE:
            begin
                n              = (amount < used) ? amount : used;
                res.space_wake = (used == CAP_CNT);
                if (st.pad_valid && n > pad_gap)
                begin
                    st_next.pad_valid = 1'b0;
                end
                st_next.tail = st.tail + n;
                res.length   = n;
            end
            default:
            begin
                st_next = st;
            end
        endcase

        used_after     = used_of(st_next.head, st_next.tail);
        res.used_bytes = used_after;
        res.free_bytes = CAP_CNT - used_after;
    end

endmodule

// File: sv/byte_ring_space_manager.sv
// Top level of the byte ring space manager: handshake, state and result registers.
// Each transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while rsp_stall is low; the head, tail and pad
// registers update as a transaction moves from the input register to the result register.
// Reset (rst_n, asynchronous, active low) empties the ring, drops any pad and
// clears both pipeline valid flags; no clearing pass is needed.
module byte_ring_space_manager
    import brsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             req_valid,
    output logic             req_stall,
    input  logic [1:0]       operation,
    input  logic [CNT_W-1:0] amount,

    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic             granted,
    output logic [POS_W-1:0] offset,
    output logic [CNT_W-1:0] length,
    output logic [CNT_W-1:0] used_bytes,
    output logic [CNT_W-1:0] free_bytes,
    output logic             data_wake,
    output logic             space_wake
);

    // Input register: holds one accepted transaction until it is processed.
    logic             in_valid_reg;
    logic [1:0]       op_reg;
    logic [CNT_W-1:0] amount_reg;

    // Ring bookkeeping.
    brsm_state_t      state_reg;
    brsm_state_t      state_next;

    // Result register: parts the ring logic from the downstream stall.
    logic             rsp_valid_reg;
    brsm_result_t     res_reg;
    brsm_result_t     res_next;

    logic             fire;
    logic             req_take;

    // A held transaction is processed whenever the result register is empty
    // or its contents leave in this same cycle.
    assign fire      = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !fire;
    assign req_take  = req_valid && !req_stall;

    brsm_core u_core
    (
        .op      (op_reg),
        .amount  (amount_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            op_reg     <= operation;
            amount_reg <= amount;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign granted    = res_reg.granted;
    assign offset     = res_reg.offset;
    assign length     = res_reg.length;
    assign used_bytes = res_reg.used_bytes;
    assign free_bytes = res_reg.free_bytes;
    assign data_wake  = res_reg.data_wake;
    assign space_wake = res_reg.space_wake;

    // The counters never drift more than one capacity apart.
    a_occupancy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.head - state_reg.tail) <= CAP_CNT)
        else $error("ring occupancy exceeds capacity");

    // A pending pad never starts at offset zero, since a region at offset
    // zero never has to wrap.
    a_pad_not_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pad_valid |-> state_reg.pad_start[POS_W-1:0] != '0)
        else $error("pad begins at ring origin");

    // Occupancy and free space always add up to the capacity.
    a_used_plus_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ({1'b0, res_reg.used_bytes} + {1'b0, res_reg.free_bytes})
                          == {1'b0, CAP_CNT})
        else $error("used and free bytes disagree");

    // A granted region never crosses the ring end.
    a_region_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && res_reg.granted) |->
            ({1'b0, 1'b0, res_reg.offset} + {1'b0, res_reg.length}) <= {1'b0, CAP_CNT})
        else $error("granted region wraps the ring end");

    // The ring state moves only when a transaction is processed.
    a_state_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("ring state changed without a transaction");

endmodule

// File: tb/sv/byte_ring_space_manager_checker.sv
// Checker for the byte ring space manager: tracks ring state and compares every result.
`timescale 1ns / 1ps
module byte_ring_space_manager_checker
    import brsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  logic [1:0]       operation,
    input  logic [CNT_W-1:0] amount,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  logic             granted,
    input  logic [POS_W-1:0] offset,
    input  logic [CNT_W-1:0] length,
    input  logic [CNT_W-1:0] used_bytes,
    input  logic [CNT_W-1:0] free_bytes,
    input  logic             data_wake,
    input  logic             space_wake,
    output int               fail_count,
    output int               pending
);

    brsm_state_t  ring;
    brsm_result_t outcome_q[$];
    brsm_result_t want;

    // Bytes between tail and head, saturated at the capacity.
    function automatic int occupancy();
        logic [CNT_W-1:0] diff;
        diff = ring.head - ring.tail;
        return (diff > CAP_CNT) ? CAPACITY : int'(diff);
    endfunction

    // Applies one operation to the tracked ring and returns the result it must give.
    function automatic brsm_result_t ring_step(input logic [1:0] op, input int amt);
        brsm_result_t     r;
        int               used;
        int               room;
        int               pos;
        int               till;
        int               n;
        logic [CNT_W-1:0] gap;
        r    = '0;
        used = occupancy();
        room = CAPACITY - used;
        case (op)
            OP_CLAIM:
            begin
                pos  = int'(ring.head[POS_W-1:0]);
                till = CAPACITY - pos;
                if (room != 0 && amt <= room)
                begin
                    if (amt <= till)
                    begin
                        r.granted = 1'b1;
                        r.offset  = POS_W'(pos);
                        r.length  = CNT_W'(amt);
                    end
                    else if (room >= till + amt && int'(ring.tail[POS_W-1:0]) >= amt)
                    begin
                        // The bytes up to the ring end become a pad; the region starts at 0.
                        ring.pad_valid = 1'b1;
                        ring.pad_start = ring.head;
                        ring.head      = ring.head + CNT_W'(till);
                        r.granted      = 1'b1;
                        r.length       = CNT_W'(amt);
                    end
                end
            end
            OP_PUBLISH:
            begin
                n           = (amt < room) ? amt : room;
                ring.head   = ring.head + CNT_W'(n);
                r.length    = CNT_W'(n);
                r.data_wake = 1'b1;
            end
            OP_PEEK:
            begin
                if (used != 0 && ring.pad_valid && ring.tail == ring.pad_start)
                begin
                    till = CAPACITY - int'(ring.tail[POS_W-1:0]);
                    if (till > used)
                        till = used;
                    if (used == CAPACITY)
                        r.space_wake = 1'b1;
                    ring.tail      = ring.tail + CNT_W'(till);
                    ring.pad_valid = 1'b0;
                    used           = used - till;
                end
                if (used != 0)
                begin
                    pos       = int'(ring.tail[POS_W-1:0]);
                    till      = CAPACITY - pos;
                    r.granted = 1'b1;
                    r.offset  = POS_W'(pos);
                    r.length  = CNT_W'((used < till) ? used : till);
                end
            end
            OP_RELEASE:
            begin
                n = (amt < used) ? amt : used;
                if (used == CAPACITY)
                    r.space_wake = 1'b1;
                gap = ring.pad_start - ring.tail;
                if (ring.pad_valid && n > int'(gap))
                    ring.pad_valid = 1'b0;
                ring.tail = ring.tail + CNT_W'(n);
                r.length  = CNT_W'(n);
            end
        endcase
        used         = occupancy();
        r.used_bytes = CNT_W'(used);
        r.free_bytes = CNT_W'(CAPACITY - used);
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Results are checked before the new request is predicted, so an edge carrying both
    // compares against expectations from earlier transactions only.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring       = '0;
            outcome_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result transaction arrived with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("granted", want.granted, granted);
                    check_field("offset", want.offset, offset);
                    check_field("length", want.length, length);
                    check_field("used_bytes", want.used_bytes, used_bytes);
                    check_field("free_bytes", want.free_bytes, free_bytes);
                    check_field("data_wake", want.data_wake, data_wake);
                    check_field("space_wake", want.space_wake, space_wake);
                end
            end
            if (req_valid && !req_stall)
                outcome_q.push_back(ring_step(operation, int'(amount)));
            pending = outcome_q.size();
        end
    end

endmodule

// File: tb/sv/byte_ring_space_manager_tb.sv
// Testbench top for the byte ring space manager: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module byte_ring_space_manager_tb;
    import brsm_pkg::*;

    // Directed transactions plus the random part; the loop stops once this many are sent.
    localparam int ITEM_TARGET  = 450;
    // Watchdog bound on the whole run, meant to leave room for a slow run with the longest
    // gaps and heavy stalls.
    localparam int CYCLE_LIMIT  = 200000;
    // Extra cycles after the last expected result catch any stray one.
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [1:0]       operation;
    logic [CNT_W-1:0] amount;
    logic             rsp_valid;
    logic             rsp_stall;
    logic             granted;
    logic [POS_W-1:0] offset;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] used_bytes;
    logic [CNT_W-1:0] free_bytes;
    logic             data_wake;
    logic             space_wake;

    int          fail_count;
    int          pending;
    int          items_sent;
    int          results_seen;
    int          burst_left;
    int          cycle_count;
    int          pick;
    logic        last_granted;
    int          msg_q[$];
    stall_mode_t stall_mode;
    int          stall_period;
    int          stall_phase;

    byte_ring_space_manager uut (.*);

    byte_ring_space_manager_checker ring_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The stimulus only needs to know how many results have come back and whether the
    // most recent one granted a region, so that a producer publishes only what it claimed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
            last_granted <= 1'b0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            results_seen <= results_seen + 1;
            last_granted <= granted;
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("byte_ring_space_manager test failed");
        $finish;
    end

    // The receiver stalls on a pattern of its own that switches between no stalls,
    // light and heavy random stalls, and a fixed period, so stalls land on every phase.
    initial
    begin
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        stall_phase = 0;
        forever
        begin
            stall_mode   = stall_mode_t'($urandom_range(0, 3));
            stall_period = $urandom_range(2, 7);
            repeat ($urandom_range(40, 200))
            begin
                @(negedge clk);
                stall_phase++;
                case (stall_mode)
                    STALL_NONE:     rsp_stall <= 1'b0;
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: rsp_stall <= ((stall_phase % stall_period) < stall_period / 2);
                    default:        rsp_stall <= 1'b0;
                endcase
            end
        end
    end

    // Presents one transaction at a falling edge and holds it until it is accepted.
    // The sender works in bursts; when a burst runs out, valid drops for a random gap.
    // Every call is entered and left at a falling edge.
    task automatic send_op(input logic [1:0] op, input logic [CNT_W-1:0] amt);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // Now and then a long burst gives a stretch with no idling at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        operation <= op;
        amount    <= amt;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drops valid and waits until every transaction sent so far has its result back.
    task automatic await_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_seen != items_sent);
    endtask

    // A well-formed producer step: claim a region, and publish it only if it was granted.
    // Published sizes are remembered so that the consumer releases whole messages, which
    // is what lets the tail land exactly on a wrap pad and exercise the pad skip.
    task automatic produce_message();
        int sel;
        int size;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            size = 0;
        else if (sel < 3)
            size = $urandom_range(1000, CAPACITY);
        else
            size = $urandom_range(1, 300);
        send_op(OP_CLAIM, CNT_W'(size));
        await_results();
        if (last_granted)
        begin
            send_op(OP_PUBLISH, CNT_W'(size));
            msg_q.push_back(size);
        end
    endtask

    // A well-formed consumer step: peek, then release the oldest whole message.
    // The peek amount is ignored by the block, so it carries random bits.
    task automatic consume_message();
        send_op(OP_PEEK, CNT_W'($urandom_range(0, 8191)));
        if (msg_q.size() != 0)
            send_op(OP_RELEASE, CNT_W'(msg_q.pop_front()));
    endtask

    // Broken sequences: random operations with amounts over the whole field, including
    // oversized ones. Afterwards the ring is emptied so message tracking starts afresh.
    task automatic noise_burst();
        int amt;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 3) == 0)
                amt = $urandom_range(0, 8191);
            else
                amt = $urandom_range(0, CAPACITY);
            send_op(2'($urandom_range(0, 3)), CNT_W'(amt));
        end
        send_op(OP_RELEASE, '1);
        msg_q.delete();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        operation  = OP_CLAIM;
        amount     = '0;
        items_sent = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Comments give the ring state the transaction should see.
        send_op(OP_PEEK, '0);                  // empty ring: nothing to read
        send_op(OP_RELEASE, '1);               // release on empty clamps to zero
        send_op(OP_CLAIM, '0);                 // zero-byte claim is granted at the head
        send_op(OP_CLAIM, CNT_W'(CAPACITY + 1)); // more than the free space: refused
        send_op(OP_CLAIM, CAP_CNT);            // whole ring, no wrap
        send_op(OP_PUBLISH, '1);               // oversized publish clamps; ring now full
        send_op(OP_CLAIM, '0);                 // full ring refuses even a zero claim
        send_op(OP_PUBLISH, CNT_W'(1));        // publish on full ring clamps to zero
        send_op(OP_PEEK, '1);                  // whole ring readable from offset 0
        send_op(OP_RELEASE, CNT_W'(96));       // release from full wakes the producer
        send_op(OP_RELEASE, '1);               // oversized release clamps; ring empty
        send_op(OP_PUBLISH, CNT_W'(4000));     // move both counters near the ring end
        send_op(OP_RELEASE, CNT_W'(4000));
        send_op(OP_CLAIM, CNT_W'(4000));       // wraps: 96-byte pad, region at offset 0
        send_op(OP_PUBLISH, CNT_W'(4000));     // pad plus data fill the ring
        send_op(OP_PEEK, '0);                  // skips the pad from a full ring
        send_op(OP_RELEASE, CNT_W'(3990));
        send_op(OP_CLAIM, CNT_W'(3995));       // wrap would not fit at offset 0: refused
        send_op(OP_CLAIM, CNT_W'(20));         // fits before the ring end
        send_op(OP_CLAIM, CNT_W'(200));        // wraps again behind a short pad
        send_op(OP_PUBLISH, CNT_W'(200));
        send_op(OP_RELEASE, CNT_W'(50));       // release runs into the pad and drops it
        send_op(OP_PEEK, '0);                  // run stops at the ring end
        send_op(OP_RELEASE, '1);
        send_op(OP_PEEK, '0);

        // Random part: mostly producer and consumer steps, with some noise.
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 46)
                produce_message();
            else if (pick < 88)
                consume_message();
            else
                noise_burst();
        end
        req_valid <= 1'b0;

        // Wait for every expected result, then a little longer for any stray one.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("byte_ring_space_manager test passed");
        else
            $display("byte_ring_space_manager test failed");
        $finish;
    end

endmodule

// File: byte_ring_space_manager.f
sv/brsm_pkg.sv
sv/brsm_core.sv
sv/byte_ring_space_manager.sv
tb/sv/byte_ring_space_manager_checker.sv
tb/sv/byte_ring_space_manager_tb.sv
